@@ hdl/ctd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared widths, register indexes and controller/datapath handshake types
// for the channelized time decimator.
// ----------------------------------------------------------------------------
package ctd_pkg;

   localparam int MAX_CHANNELS   = 4096;
   localparam int MAX_DECIMATION = 1024;

   localparam int CH_W     = $clog2(MAX_CHANNELS);          // channel index
   localparam int NCH_W    = $clog2(MAX_CHANNELS) + 1;      // channel count
   localparam int ROW_W    = $clog2(MAX_DECIMATION);        // row within block
   localparam int FAC_W    = $clog2(MAX_DECIMATION) + 1;    // decimation factor
   localparam int SAMPLE_W = 8;
   localparam int SUM_W    = SAMPLE_W + ROW_W;              // per channel sum
   localparam int NUM_W    = SUM_W + 1;                     // sum plus rounding
   localparam int STEP_W   = $clog2(SAMPLE_W);              // divider step count

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = NCH_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATION_FACTOR = 1'd1;

   localparam logic [NCH_W-1:0] CHANNEL_COUNT_RESET     = NCH_W'(MAX_CHANNELS);
   localparam logic [FAC_W-1:0] DECIMATION_FACTOR_RESET = FAC_W'(1);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   typedef struct packed {
      logic accept;     // input transfer this cycle
      logic clear_wr;   // write one zero of the post-reset clearing pass
      logic add;        // sum update and divider load
      logic div_step;   // one quotient bit
      logic out_load;   // move the finished mean into the output register
   } ctd_cmd_type;

   typedef struct packed {
      logic last_row;   // accepted sample closes its block
      logic clear_last; // clearing pass is at its final entry
      logic out_free;   // output register can take a result this cycle
   } ctd_status_type;

endpackage

@@ hdl/ctd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ctd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ctd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_ctrl
// Sequencer: clearing pass after reset, then one item at a time: accept, sum
// update and, on a last row, bit-serial divide and result hand-off.
// ----------------------------------------------------------------------------
module ctd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ctd_pkg::ctd_status_type status,
   output ctd_pkg::ctd_cmd_type    cmd
);
   import ctd_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            step_in = '0;
            state_in = status.last_row ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (&step_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

@@ hdl/ctd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_datapath
// Configuration registers, channel/row position, per channel sum RAM,
// restoring divider for the rounded mean and the output register.
// ----------------------------------------------------------------------------
module ctd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [ctd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ctd_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic [ctd_pkg::SAMPLE_W-1:0]          req_sample,
   input  ctd_pkg::ctd_cmd_type                  cmd,
   output ctd_pkg::ctd_status_type               status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ctd_pkg::SAMPLE_W-1:0]          rsp_mean_sample,
   output logic [ctd_pkg::CH_W-1:0]              rsp_out_channel,
   output logic                                  rsp_row_end
);
   import ctd_pkg::*;

   // configuration
   logic [NCH_W-1:0] channel_count_ff;
   logic [FAC_W-1:0] decimation_factor_ff;
   logic [NCH_W-1:0] nch;
   logic [FAC_W-1:0] fac;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff     <= CHANNEL_COUNT_RESET;
         decimation_factor_ff <= DECIMATION_FACTOR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CHANNEL_COUNT:     channel_count_ff     <= csr_write_data;
            CSR_DECIMATION_FACTOR: decimation_factor_ff <= csr_write_data[FAC_W-1:0];
            default: ;
         endcase
      end
   end

   // zero means one, anything above the maximum saturates
   always_comb begin
      nch = channel_count_ff;
      if (channel_count_ff == '0) begin
         nch = NCH_W'(1);
      end else if (channel_count_ff > NCH_W'(MAX_CHANNELS)) begin
         nch = NCH_W'(MAX_CHANNELS);
      end
      fac = decimation_factor_ff;
      if (decimation_factor_ff == '0) begin
         fac = FAC_W'(1);
      end else if (decimation_factor_ff > FAC_W'(MAX_DECIMATION)) begin
         fac = FAC_W'(MAX_DECIMATION);
      end
   end

   // position of the next sample
   logic [CH_W-1:0]  position_ff, position_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CH_W-1:0]  ch_cur;
   logic [NCH_W-1:0] ch_next;
   logic [FAC_W-1:0] row_next;
   logic             last_chan_cur, last_row_cur;

   always_comb begin
      ch_cur        = ({1'b0, position_ff} >= nch) ? '0 : position_ff;
      ch_next       = {1'b0, ch_cur} + 1'b1;
      row_next      = {1'b0, row_ff} + 1'b1;
      last_chan_cur = (ch_next >= nch);
      last_row_cur  = (row_next >= fac);
      position_in   = last_chan_cur ? '0 : ch_next[CH_W-1:0];
      row_in        = row_ff;
      if (last_chan_cur) begin
         row_in = last_row_cur ? '0 : row_next[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         row_ff      <= '0;
      end else if (cmd.accept) begin
         position_ff <= position_in;
         row_ff      <= row_in;
      end
   end

   // accepted item
   logic [SAMPLE_W-1:0] sample_ff;
   logic [CH_W-1:0]     ch_ff;
   logic                last_row_ff;
   logic                last_chan_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff    <= req_sample;
         ch_ff        <= ch_cur;
         last_row_ff  <= last_row_cur;
         last_chan_ff <= last_chan_cur;
      end
   end

   // clearing pass address
   logic [CH_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // per channel sums
   logic [SUM_W-1:0] rd_sum;
   logic [SUM_W-1:0] new_sum;
   logic             ram_wr_en;
   logic [CH_W-1:0]  ram_wr_addr;
   logic [SUM_W-1:0] ram_wr_data;

   assign new_sum     = rd_sum + SUM_W'(sample_ff);
   assign ram_wr_en   = cmd.clear_wr | cmd.add;
   assign ram_wr_addr = cmd.clear_wr ? clr_addr_ff : ch_ff;
   assign ram_wr_data = (cmd.clear_wr || last_row_ff) ? '0 : new_sum;

   ctd_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_CHANNELS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ch_cur),
      .rd_data (rd_sum)
   );

   // rounded mean: quotient above 255 is caught by one compare, the
   // remaining eight quotient bits come one per cycle
   logic [NUM_W-1:0]    numer;
   logic [NUM_W-1:0]    sat_limit;
   logic [FAC_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic                sat_ff;
   logic [FAC_W:0]      trial;
   logic [FAC_W:0]      trial_diff;
   logic                trial_ge;

   assign numer     = NUM_W'(new_sum) + NUM_W'(fac >> 1);
   assign sat_limit = {fac, {SAMPLE_W{1'b0}}};

   always_comb begin
      trial      = {rem_ff, quo_ff[SAMPLE_W-1]};
      trial_diff = trial - {1'b0, fac};
      trial_ge   = (trial >= {1'b0, fac});
      rem_in     = trial_ge ? trial_diff[FAC_W-1:0] : trial[FAC_W-1:0];
      quo_in     = {quo_ff[SAMPLE_W-2:0], trial_ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         sat_ff <= (numer >= sat_limit);
         rem_ff <= numer[NUM_W-1:SAMPLE_W];
         quo_ff <= numer[SAMPLE_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // output register
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_mean_ff;
   logic [CH_W-1:0]     rsp_ch_ff;
   logic                rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_mean_ff <= sat_ff ? SAMPLE_MAX : quo_ff;
         rsp_ch_ff   <= ch_ff;
         rsp_end_ff  <= last_chan_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_sample = rsp_mean_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_row_end     = rsp_end_ff;

   assign status.last_row   = last_row_ff;
   assign status.clear_last = &clr_addr_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

@@ hdl/channelized_time_decimator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channelized_time_decimator_unit
// Per channel boxcar decimator: sums decimation_factor rows of 8-bit samples
// per channel and emits the rounded, saturated mean on the last row.
// ----------------------------------------------------------------------------
// After reset the block zeroes every entry of the per channel sum RAM,
// with req_stall high; configuration writes are taken during that time. It
// then handles one sample at a time. A sample that does not close its block
// goes through the transfer and then a RAM read-modify-write of the channel
// sum. A sample on the last row of a block passes, before the next transfer,
// through the sum update, the bit-serial divider that forms the mean, and
// the load of the output register. The output register holds a finished
// mean until it is taken, and the next sample is accepted meanwhile; only
// the next mean waits for the register to empty.
module channelized_time_decimator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [ctd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ctd_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ctd_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ctd_pkg::SAMPLE_W-1:0]   rsp_mean_sample,
   output logic [ctd_pkg::CH_W-1:0]       rsp_out_channel,
   output logic                           rsp_row_end
);
   import ctd_pkg::*;

   ctd_cmd_type    cmd;
   ctd_status_type status;

   ctd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ctd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_sample  (rsp_mean_sample),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_row_end      (rsp_row_end)
   );

`ifndef SYNTHESIS
   // one sample in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("transfer accepted while previous sample still in flight");

   // a mean is never loaded over one that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("output register overwritten before transfer");

   // a result only appears after the divider has finished
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result valid without a divider result");
`endif

endmodule
